// ===== rtl/u16u8_pkg.sv =====
`default_nettype none
package u16u8_pkg;

	// surrogate tags in the upper six bits of a code unit
	localparam logic [5:0] HI_TAG = 6'b110110;
	localparam logic [5:0] LO_TAG = 6'b110111;

	// longest byte run that one code unit can cause
	localparam int MAX_BYTES = 6;
	localparam int CNT_W     = 3;

	localparam logic [20:0] SUPP_BASE = 21'h010000;

	typedef logic [MAX_BYTES-1:0][7:0] byte_run_t;
	typedef logic [CNT_W-1:0]          byte_cnt_t;

	// transcoder state carried between code units
	typedef struct packed {
		logic [9:0] held_high;
		logic       held_valid;
		logic       terminated;
	} enc_state_t;

	// serialiser status seen by the front end
	typedef struct packed {
		logic busy;
		logic done;
	} ser_stat_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
	} cp_enc_t;

	// utf-8 byte sequence of one code point, first byte in slot 0
	function automatic cp_enc_t cp_encode(input logic [20:0] cp);
		cp_enc_t r;
		r.bytes = '0;
		if (cp < 21'h000080) begin
			r.bytes[0] = {1'b0, cp[6:0]};
			r.len      = 3'd1;
		end else if (cp < 21'h000800) begin
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
			r.len      = 3'd2;
		end else if (cp < SUPP_BASE) begin
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
			r.len      = 3'd3;
		end else begin
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
			r.len      = 3'd4;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/utf16_to_utf8_transcoder.sv =====
// utf-16 to utf-8 transcoder
//
// input channel: code_unit plus last_unit, moved by in_valid / in_stall. a
// request is taken at a clock edge with in_valid high and in_stall low.
// output channel: out_byte plus last_of_run, moved by out_valid / out_stall,
// one byte per request; last_of_run flags the final byte caused by one unit.
// a unit that causes no byte (held high surrogate, terminator, dropped unit)
// yields no output request at all.
//
// a taken unit passes from the input register into the serialiser's run
// register once the serialiser is free. throughput: the output register
// moves one byte a cycle while out_stall is low; a unit causes 1 to 6 bytes
// (typically 1 to 3 for bmp text), and a unit with no bytes leaves the input register without loading the serialiser.
// the input register takes the next unit while the current run drains.
//
// reset clears the held surrogate, the terminated flag and both valid bits.
// while the receiver stalls the current byte holds, and once the input
// register fills in_stall rises to back-pressure the sender.
`default_nettype none
module utf16_to_utf8_transcoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] code_unit,
	input  wire logic        last_unit,
	input  wire logic        in_valid,
	output logic             in_stall,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic             out_valid,
	input  wire logic        out_stall
);

	// input register
	logic [15:0] unit_s1;
	logic        last_s1;
	logic        valid_s1;

	// transcoder state
	u16u8_pkg::enc_state_t st_q;
	u16u8_pkg::enc_state_t st_next;

	u16u8_pkg::byte_run_t run;
	u16u8_pkg::byte_cnt_t cnt;
	u16u8_pkg::ser_stat_t stat;

	logic advance;
	logic load;

	// the input register drains into the serialiser once it is free, or
	// in the very cycle its last byte is taken
	assign advance  = valid_s1 && (!stat.busy || stat.done);
	assign load     = advance && (cnt != '0);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			// state moves with the unit as it leaves the input register
			if (advance) begin
				st_q <= st_next;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			unit_s1 <= code_unit;
			last_s1 <= last_unit;
		end
	end

	u16u8_enc u_enc (
		.unit    (unit_s1),
		.last    (last_s1),
		.st      (st_q),
		.st_next (st_next),
		.run     (run),
		.cnt     (cnt)
	);

	u16u8_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.run         (run),
		.cnt         (cnt),
		.stat        (stat),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.out_valid   (out_valid),
		.out_stall   (out_stall)
	);

	// a held surrogate is always flushed before the string can terminate
	a_held_not_term: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.held_valid && st_q.terminated))
		else $error("held surrogate while terminated");

	// nothing is emitted for a unit that arrives while terminated
	a_drop_when_term: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && st_q.terminated) |-> !load)
		else $error("bytes emitted while terminated");

	// the state only changes as a unit leaves the input register
	a_state_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) |-> $stable(st_q))
		else $error("state changed without a unit");

endmodule
`default_nettype wire

// ===== rtl/u16u8_enc.sv =====
`default_nettype none
module u16u8_enc (
	input  wire logic [15:0]           unit,
	input  wire logic                  last,
	input  wire u16u8_pkg::enc_state_t st,
	output u16u8_pkg::enc_state_t      st_next,
	output u16u8_pkg::byte_run_t       run,
	output u16u8_pkg::byte_cnt_t       cnt
);

	logic              is_hi;
	logic              is_lo;
	logic              pair;
	logic              flush;
	logic              emit_unit;
	logic [20:0]       pair_cp;
	u16u8_pkg::cp_enc_t unit_enc;
	u16u8_pkg::cp_enc_t pair_enc;
	u16u8_pkg::cp_enc_t flush_enc;

	assign is_hi = unit[15:10] == u16u8_pkg::HI_TAG;
	assign is_lo = unit[15:10] == u16u8_pkg::LO_TAG;

	assign pair_cp   = u16u8_pkg::SUPP_BASE + {1'b0, st.held_high, unit[9:0]};
	assign unit_enc  = u16u8_pkg::cp_encode({5'd0, unit});
	assign pair_enc  = u16u8_pkg::cp_encode(pair_cp);
	assign flush_enc = u16u8_pkg::cp_encode({5'd0, u16u8_pkg::HI_TAG, st.held_high});

	assign pair      = !st.terminated && st.held_valid && is_lo;
	assign flush     = !st.terminated && st.held_valid && !is_lo;
	assign emit_unit = !st.terminated && !pair && (unit != 16'd0) && !(is_hi && !last);

	always_comb begin
		st_next = st;
		run     = '0;
		cnt     = '0;
		if (st.terminated) begin
			st_next.terminated = !last;
		end else if (pair) begin
			st_next.held_valid = 1'b0;
			st_next.held_high  = '0;
			run[3:0]           = pair_enc.bytes;
			cnt                = pair_enc.len;
		end else begin
			st_next.held_valid = 1'b0;
			st_next.held_high  = '0;
			if (unit == 16'd0) begin
				st_next.terminated = !last;
			end else if (is_hi && !last) begin
				st_next.held_valid = 1'b1;
				st_next.held_high  = unit[9:0];
			end
			if (flush) begin
				// held unit goes first, the new unit's bytes follow it
				run[2:0] = flush_enc.bytes[2:0];
				run[5:3] = unit_enc.bytes[2:0];
				cnt      = 3'd3 + (emit_unit ? unit_enc.len : 3'd0);
			end else if (emit_unit) begin
				run[3:0] = unit_enc.bytes;
				cnt      = unit_enc.len;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/u16u8_ser.sv =====
`default_nettype none
module u16u8_ser (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire u16u8_pkg::byte_run_t   run,
	input  wire u16u8_pkg::byte_cnt_t   cnt,
	output u16u8_pkg::ser_stat_t        stat,
	output logic [7:0]                  out_byte,
	output logic                        last_of_run,
	output logic                        out_valid,
	input  wire logic                   out_stall
);

	u16u8_pkg::byte_run_t run_s2;
	u16u8_pkg::byte_cnt_t cnt_s2;
	u16u8_pkg::byte_cnt_t idx_q;
	logic                 valid_s2;
	logic                 take;

	assign take        = valid_s2 && !out_stall;
	assign last_of_run = idx_q == (cnt_s2 - 3'd1);
	assign out_byte    = run_s2[idx_q];
	assign out_valid   = valid_s2;
	assign stat.busy   = valid_s2;
	assign stat.done   = take && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (stat.done) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			run_s2 <= run;
			cnt_s2 <= cnt;
		end
	end

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q < cnt_s2 && cnt_s2 != 3'd0))
		else $error("byte index beyond run");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_s2 || stat.done))
		else $error("run loaded over a pending run");

	a_step_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !last_of_run && !load) |=> (idx_q == $past(idx_q) + 3'd1))
		else $error("byte index did not advance");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// quiet cycles in which neither side moves a request before the run is abandoned
	localparam int unsigned STALL_LIMIT = 2000;
	// length of the deliberate receiver hold-off, in cycles
	localparam int unsigned HOLD_CYCLES = 80;
	// random part stops once this many units are queued
	localparam int unsigned RANDOM_UNITS = 350;

	// one code unit waiting to be offered; drain_first holds it back until
	// every byte predicted so far has come out
	typedef struct {
		logic [15:0] value;
		logic        last;
		logic        drain_first;
	} unit_req_t;

	// one predicted output request
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} utf8_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [15:0] code_unit = '0;
	logic        last_unit = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        out_valid;
	logic        out_stall = 1'b0;

	unit_req_t   pending_units[$];
	utf8_byte_t  expected_bytes[$];

	// transcoder state as the predictor sees it
	logic [9:0]  held_high_q = '0;
	logic        held_valid_q = 1'b0;
	logic        terminated_q = 1'b0;

	int unsigned units_taken = 0;
	int unsigned failures = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	int unsigned quiet_cycles = 0;

	utf16_to_utf8_transcoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.code_unit   (code_unit),
		.last_unit   (last_unit),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.out_valid   (out_valid),
		.out_stall   (out_stall)
	);

	always #5 clk = ~clk;

	// no random gaps or stalls on either side over a stretch of the random part
	function automatic logic calm_stretch();
		return units_taken >= 240 && units_taken < 330;
	endfunction

	// utf-8 bytes of one code point onto the expected store, run flag clear
	function automatic int push_code_point(input logic [20:0] cp);
		utf8_byte_t b;
		b.last = 1'b0;
		if (cp < 21'h80) begin
			b.value = cp[7:0];
			expected_bytes.push_back(b);
			return 1;
		end else if (cp < 21'h800) begin
			b.value = 8'hc0 | cp[10:6];
			expected_bytes.push_back(b);
			b.value = 8'h80 | cp[5:0];
			expected_bytes.push_back(b);
			return 2;
		end else if (cp < u16u8_pkg::SUPP_BASE) begin
			b.value = 8'he0 | cp[15:12];
			expected_bytes.push_back(b);
			b.value = 8'h80 | cp[11:6];
			expected_bytes.push_back(b);
			b.value = 8'h80 | cp[5:0];
			expected_bytes.push_back(b);
			return 3;
		end
		b.value = 8'hf0 | cp[20:18];
		expected_bytes.push_back(b);
		b.value = 8'h80 | cp[17:12];
		expected_bytes.push_back(b);
		b.value = 8'h80 | cp[11:6];
		expected_bytes.push_back(b);
		b.value = 8'h80 | cp[5:0];
		expected_bytes.push_back(b);
		return 4;
	endfunction

	// flag the final byte of the run just predicted
	function automatic void close_run();
		utf8_byte_t b;
		b = expected_bytes.pop_back();
		b.last = 1'b1;
		expected_bytes.push_back(b);
	endfunction

	// predict the bytes one accepted code unit causes, updating the state
	function automatic void transcode_unit(input logic [15:0] u, input logic last);
		int n;
		n = 0;
		// after a terminator everything is dropped until the final unit
		if (terminated_q) begin
			if (last)
				terminated_q = 1'b0;
			return;
		end
		if (held_valid_q) begin
			held_valid_q = 1'b0;
			// high then low surrogate: one supplementary code point
			if (u[15:10] == u16u8_pkg::LO_TAG) begin
				void'(push_code_point(u16u8_pkg::SUPP_BASE + {1'b0, held_high_q, u[9:0]}));
				held_high_q = '0;
				close_run();
				return;
			end
			// anything else flushes the held high surrogate on its own
			n += push_code_point({5'b0, u16u8_pkg::HI_TAG, held_high_q});
			held_high_q = '0;
		end
		if (u == 16'h0000) begin
			if (!last)
				terminated_q = 1'b1;
		end else if (u[15:10] == u16u8_pkg::HI_TAG && !last) begin
			held_high_q = u[9:0];
			held_valid_q = 1'b1;
		end else begin
			n += push_code_point({5'b0, u});
		end
		if (n > 0)
			close_run();
	endfunction

	function automatic void queue_unit(input logic [15:0] u, input logic last,
			input logic drain_first = 1'b0);
		unit_req_t r;
		r.value = u;
		r.last = last;
		r.drain_first = drain_first;
		pending_units.push_back(r);
	endfunction

	// a bmp code unit outside the surrogate range that needs three bytes
	function automatic logic [15:0] wide_bmp();
		if ($urandom_range(1))
			return 16'($urandom_range(16'hd7ff, 16'h0800));
		return 16'($urandom_range(16'hffff, 16'he000));
	endfunction

	// random strings, mostly well formed, closed by the final-unit flag
	function automatic void queue_random_strings();
		logic [15:0] str[$];
		int unsigned queued;
		int unsigned len;
		int unsigned pick;
		logic        drain;
		logic        drained_early;
		logic        drained_late;
		queued = 0;
		drained_early = 1'b0;
		drained_late = 1'b0;
		while (queued < RANDOM_UNITS) begin
			str.delete();
			len = $urandom_range(10, 1);
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(99);
				if (pick < 25)
					str.push_back(16'($urandom_range(16'h7f, 16'h01)));
				else if (pick < 40)
					str.push_back(16'($urandom_range(16'h7ff, 16'h80)));
				else if (pick < 60)
					str.push_back(wide_bmp());
				else if (pick < 78) begin
					str.push_back({u16u8_pkg::HI_TAG, 10'($urandom)});
					str.push_back({u16u8_pkg::LO_TAG, 10'($urandom)});
				end else if (pick < 83)
					str.push_back({u16u8_pkg::HI_TAG, 10'($urandom)});
				else if (pick < 87)
					str.push_back({u16u8_pkg::LO_TAG, 10'($urandom)});
				else if (pick < 91) begin
					// terminator followed by units that get dropped
					str.push_back(16'h0000);
					repeat ($urandom_range(3))
						str.push_back(16'($urandom));
				end else
					str.push_back(16'($urandom));
			end
			// two pauses where the sender waits for the output to empty
			drain = 1'b0;
			if (!drained_early && queued >= 120) begin
				drain = 1'b1;
				drained_early = 1'b1;
			end else if (!drained_late && queued >= 290) begin
				drain = 1'b1;
				drained_late = 1'b1;
			end
			foreach (str[i]) begin
				// the odd broken string runs into the next, the odd flag comes early
				queue_unit(str[i],
					(i == str.size() - 1) ? ($urandom_range(99) >= 8)
						: ($urandom_range(99) < 3),
					drain && i == 0);
			end
			queued += str.size();
		end
	endfunction

	// sender: keeps a request up until taken, then offers the next or idles
	always @(posedge clk) begin : drive_units
		unit_req_t next_req;
		logic      gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				transcode_unit(code_unit, last_unit);
				units_taken++;
			end
			if (!(in_valid && in_stall)) begin
				// keep offering through the receiver hold-off so the block fills
				gap = hold_left == 0 && !calm_stretch() && $urandom_range(99) < 31;
				if (pending_units.size() > 0 && !gap
						&& !(pending_units[0].drain_first && expected_bytes.size() > 0)) begin
					next_req = pending_units.pop_front();
					code_unit <= next_req.value;
					last_unit <= next_req.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each byte against the oldest prediction
	always @(posedge clk) begin : check_bytes
		utf8_byte_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("out_byte expected none, got %h", out_byte);
					failures++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.value) begin
						$error("out_byte expected %h, got %h", want.value, out_byte);
						failures++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run expected %b, got %b", want.last, last_of_run);
						failures++;
					end
				end
			end
			// one long hold-off early in the random part, then random stalls
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && units_taken >= 100) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm_stretch() && $urandom_range(99) < 31;
			end
		end
	end

	// watchdog on cycles where neither channel moves a request
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		// field extremes and the byte-length boundaries
		queue_unit(16'h0001, 1'b0);
		queue_unit(16'h007f, 1'b0);
		queue_unit(16'h0080, 1'b0);
		queue_unit(16'h07ff, 1'b0);
		queue_unit(16'h0800, 1'b0);
		queue_unit(16'hffff, 1'b0);
		// lowest and highest surrogate pairs
		queue_unit(16'hd800, 1'b0);
		queue_unit(16'hdc00, 1'b0);
		queue_unit(16'hdbff, 1'b0);
		queue_unit(16'hdfff, 1'b0);
		// held high surrogate flushed by an ordinary unit
		queue_unit(16'hd800, 1'b0);
		queue_unit(16'h0041, 1'b0);
		// held high flushed by another high, which then goes out with 0xffff
		queue_unit(16'hdbff, 1'b0);
		queue_unit(16'hd800, 1'b0);
		queue_unit(16'hffff, 1'b0);
		// lone low surrogate, and a high surrogate as the final unit
		queue_unit(16'hdc00, 1'b0);
		queue_unit(16'hd912, 1'b1);
		// terminator flushes the held unit, then units drop until the flag
		queue_unit(16'hd800, 1'b0);
		queue_unit(16'h0000, 1'b0);
		queue_unit(16'h0041, 1'b0);
		queue_unit(16'hd800, 1'b0);
		queue_unit(16'h1234, 1'b1);
		// terminator as the final unit just ends the string
		queue_unit(16'hd801, 1'b0);
		queue_unit(16'h0000, 1'b1);
		// pair completed by a final low surrogate
		queue_unit(16'hda00, 1'b0);
		queue_unit(16'hde00, 1'b1);
		queue_random_strings();

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_units.size() > 0 || in_valid)
			@(posedge clk);
		while (expected_bytes.size() > 0)
			@(posedge clk);
		// let any stray byte surface before closing
		repeat (30) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
